>>> hw/rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// shared constants, byte codes and control types of the telnet stream parser
// ----------------------------------------------------------------------------
package tsp_pkg;

    // payload store geometry
    localparam int PAYLOAD_DEPTH = 16;
    localparam int IDX_W         = 4;
    localparam int CNT_W         = 5;
    localparam logic [CNT_W-1:0] MAX_RUN = 5'd16;

    // telnet byte codes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;

    // result kinds
    localparam logic [1:0] KIND_TEXT    = 2'd0;
    localparam logic [1:0] KIND_CMD     = 2'd1;
    localparam logic [1:0] KIND_OPTION  = 2'd2;
    localparam logic [1:0] KIND_PAYLOAD = 2'd3;

    // which result the output register is loaded with
    typedef enum logic [2:0] {
        EM_NONE,
        EM_TEXT,
        EM_IAC,
        EM_CMD,
        EM_OPT,
        EM_EMPTY,
        EM_PAYLOAD
    } t_emit;

    // controller to datapath
    typedef struct packed {
        t_emit emit;
        logic  store_byte;
        logic  store_iac;
        logic  store_hold;
        logic  clr_count;
        logic  load_pend;
        logic  load_hold;
        logic  rd_reset;
        logic  rd_advance;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_iac;
        logic is_se;
        logic is_sb;
        logic is_opt;
        logic cnt_zero;
        logic out_free;
        logic run_end;
    } t_sts;

endpackage

>>> hw/rtl/tsp_dpath.sv
// ----------------------------------------------------------------------------
// tsp_dpath
// byte decode, payload store, read pointer and result register
// ----------------------------------------------------------------------------
module tsp_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_res_stall,
    input  tsp_pkg::t_cmd       i_cmd,
    output tsp_pkg::t_sts       o_sts,
    output logic                o_res_valid,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_data_byte,
    output logic [7:0]          o_command_code,
    output logic [7:0]          o_option_code,
    output logic [4:0]          o_payload_length,
    output logic [3:0]          o_payload_index,
    output logic                o_last
);

    logic [7:0] r_mem [tsp_pkg::PAYLOAD_DEPTH];
    logic [7:0] r_rd_data;

    logic [tsp_pkg::CNT_W-1:0] r_count, n_count;
    logic [tsp_pkg::IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [7:0] r_pend, r_hold, r_first;
    logic [tsp_pkg::CNT_W-1:0] run_len;

    logic       wr_en;
    logic [7:0] wr_data;

    logic       r_out_valid, n_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_data, r_cmd, r_opt;
    logic [4:0] r_len;
    logic [3:0] r_idx;
    logic       r_last;

    // byte decode and status
    always_comb begin
        o_sts.is_iac   = (i_rx_byte == tsp_pkg::B_IAC);
        o_sts.is_se    = (i_rx_byte == tsp_pkg::B_SE);
        o_sts.is_sb    = (i_rx_byte == tsp_pkg::B_SB);
        o_sts.is_opt   = (i_rx_byte >= tsp_pkg::B_WILL) && (i_rx_byte <= tsp_pkg::B_DONT);
        o_sts.cnt_zero = (r_count == '0);
        o_sts.out_free = !r_out_valid || !i_res_stall;
        o_sts.run_end  = ({1'b0, r_rd_idx} + 5'd1) == run_len;
    end

    assign run_len = (r_count > tsp_pkg::MAX_RUN) ? tsp_pkg::MAX_RUN : r_count;

    // store write port: one entry a cycle, dropped once full
    always_comb begin
        wr_data = i_rx_byte;
        if (i_cmd.store_iac) begin
            wr_data = tsp_pkg::B_IAC;
        end else if (i_cmd.store_hold) begin
            wr_data = r_hold;
        end
        wr_en = (i_cmd.store_byte || i_cmd.store_iac || i_cmd.store_hold)
                && (r_count < tsp_pkg::CNT_W'(tsp_pkg::PAYLOAD_DEPTH));
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clr_count) begin
            n_count = '0;
        end else if (wr_en) begin
            n_count = r_count + 1'b1;
        end
        n_rd_idx = r_rd_idx;
        if (i_cmd.rd_reset) begin
            n_rd_idx = '0;
        end else if (i_cmd.rd_advance) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[tsp_pkg::IDX_W-1:0]] <= wr_data;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= '0;
            r_rd_idx <= '0;
        end else begin
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            if (i_cmd.load_pend) begin
                r_pend <= i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hold) begin
            r_hold <= i_rx_byte;
        end
        if (wr_en && (r_count == '0)) begin
            r_first <= wr_data;
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid && i_res_stall;
        if (i_cmd.emit != tsp_pkg::EM_NONE) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != tsp_pkg::EM_NONE) begin
            r_kind <= tsp_pkg::KIND_TEXT;
            r_data <= '0;
            r_cmd  <= '0;
            r_opt  <= '0;
            r_len  <= '0;
            r_idx  <= '0;
            r_last <= 1'b1;
            unique case (i_cmd.emit)
                tsp_pkg::EM_TEXT: begin
                    r_data <= i_rx_byte;
                end
                tsp_pkg::EM_IAC: begin
                    r_data <= tsp_pkg::B_IAC;
                end
                tsp_pkg::EM_CMD: begin
                    r_kind <= tsp_pkg::KIND_CMD;
                    r_cmd  <= i_rx_byte;
                end
                tsp_pkg::EM_OPT: begin
                    r_kind <= tsp_pkg::KIND_OPTION;
                    r_cmd  <= r_pend;
                    r_opt  <= i_rx_byte;
                end
                tsp_pkg::EM_EMPTY: begin
                    r_kind <= tsp_pkg::KIND_PAYLOAD;
                    r_cmd  <= r_pend;
                end
                tsp_pkg::EM_PAYLOAD: begin
                    r_kind <= tsp_pkg::KIND_PAYLOAD;
                    r_data <= r_rd_data;
                    r_cmd  <= r_pend;
                    r_opt  <= r_first;
                    r_len  <= run_len;
                    r_idx  <= r_rd_idx;
                    r_last <= o_sts.run_end;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data;
    assign o_command_code   = r_cmd;
    assign o_option_code    = r_opt;
    assign o_payload_length = r_len;
    assign o_payload_index  = r_idx;
    assign o_last           = r_last;

endmodule

>>> hw/rtl/tsp_ctrl.sv
// ----------------------------------------------------------------------------
// tsp_ctrl
// parse state machine, input stall and datapath commands
// ----------------------------------------------------------------------------
module tsp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rx_valid,
    input  tsp_pkg::t_sts  i_sts,
    output logic           o_rx_stall,
    output tsp_pkg::t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_TEXT  = 8'b0000_0001,
        S_CMD   = 8'b0000_0010,
        S_OPT   = 8'b0000_0100,
        S_SB    = 8'b0000_1000,
        S_SBIAC = 8'b0001_0000,
        S_SBESC = 8'b0010_0000,
        S_BRD   = 8'b0100_0000,
        S_BEMIT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   busy;
    logic   fire;

    // busy states take no byte
    assign busy       = (r_state == S_SBESC) || (r_state == S_BRD) || (r_state == S_BEMIT);
    assign o_rx_stall = busy || !i_sts.out_free;
    assign fire       = i_rx_valid && !o_rx_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit = tsp_pkg::EM_NONE;
        unique case (r_state)
            S_CMD: begin
                if (fire) begin
                    n_state = S_TEXT;
                    if (i_sts.is_iac) begin
                        o_cmd.emit = tsp_pkg::EM_IAC;
                    end else if (i_sts.is_opt) begin
                        o_cmd.load_pend = 1'b1;
                        n_state = S_OPT;
                    end else if (i_sts.is_sb) begin
                        o_cmd.load_pend = 1'b1;
                        o_cmd.clr_count = 1'b1;
                        n_state = S_SB;
                    end else if (!i_sts.is_se) begin
                        o_cmd.emit = tsp_pkg::EM_CMD;
                    end
                end
            end
            S_OPT: begin
                if (fire) begin
                    o_cmd.emit = tsp_pkg::EM_OPT;
                    n_state = S_TEXT;
                end
            end
            S_SB: begin
                if (fire) begin
                    if (i_sts.is_iac) begin
                        n_state = S_SBIAC;
                    end else begin
                        o_cmd.store_byte = 1'b1;
                    end
                end
            end
            S_SBIAC: begin
                if (fire) begin
                    if (i_sts.is_se) begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.emit = tsp_pkg::EM_EMPTY;
                            n_state = S_TEXT;
                        end else begin
                            o_cmd.rd_reset = 1'b1;
                            n_state = S_BRD;
                        end
                    end else if (i_sts.is_iac) begin
                        o_cmd.store_byte = 1'b1;
                        n_state = S_SB;
                    end else begin
                        o_cmd.store_iac = 1'b1;
                        o_cmd.load_hold = 1'b1;
                        n_state = S_SBESC;
                    end
                end
            end
            S_SBESC: begin
                o_cmd.store_hold = 1'b1;
                n_state = S_SB;
            end
            S_BRD: begin
                n_state = S_BEMIT;
            end
            S_BEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = tsp_pkg::EM_PAYLOAD;
                    if (i_sts.run_end) begin
                        n_state = S_TEXT;
                    end else begin
                        o_cmd.rd_advance = 1'b1;
                        n_state = S_BRD;
                    end
                end
            end
            default: begin
                if (fire) begin
                    if (i_sts.is_iac) begin
                        n_state = S_CMD;
                    end else begin
                        o_cmd.emit = tsp_pkg::EM_TEXT;
                        n_state = S_TEXT;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TEXT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/telnet_stream_parser_top.sv
// ----------------------------------------------------------------------------
// telnet_stream_parser_top
// splits a received telnet byte stream into text, commands and payload runs
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// rx        in         i_rx_valid / o_rx_stall    i_rx_byte
// res       out        o_res_valid / i_res_stall  kind, data, command, option,
//                                                 length, index, last
//
// one byte per cycle while the result register drains; results other than
// payload runs are registered and appear in the cycle after the byte
// that causes them; a payload run reads each stored byte (registered store
// read) and then emits it; input is stalled for the whole run and while an
// escape that stores two bytes writes the second (single store write port)
// reset is synchronous, active low; the payload store holds no reset value
// ----------------------------------------------------------------------------
module telnet_stream_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // rx byte transfer
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    // result transfer
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_command_code,
    output logic [7:0] o_option_code,
    output logic [4:0] o_payload_length,
    output logic [3:0] o_payload_index,
    output logic       o_last
);

    tsp_pkg::t_cmd cmd;
    tsp_pkg::t_sts sts;

    // parse state machine
    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_sts      (sts),
        .o_rx_stall (o_rx_stall),
        .o_cmd      (cmd)
    );

    // decode, store and result register
    tsp_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_res_stall      (i_res_stall),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_res_valid      (o_res_valid),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_command_code   (o_command_code),
        .o_option_code    (o_option_code),
        .o_payload_length (o_payload_length),
        .o_payload_index  (o_payload_index),
        .o_last           (o_last)
    );

    // result register is only loaded when it is empty or draining
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit != tsp_pkg::EM_NONE) |-> sts.out_free)
        else $error("result register overwritten while stalled");

    // no byte is taken during a payload run
    a_run_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit == tsp_pkg::EM_PAYLOAD) |-> o_rx_stall)
        else $error("rx transfer during payload run");

    // payload index stays inside the reported run
    a_index_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_kind == tsp_pkg::KIND_PAYLOAD) && (o_payload_length != 5'd0))
        |-> ({1'b0, o_payload_index} < o_payload_length))
        else $error("payload index beyond run length");

endmodule
